>>> rtl/aescbc_pkg.sv
package aescbc_pkg;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
    logic        restart;
  } in_item_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } out_item_t;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IV_HIGH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IV_LOW   = 2'd3;

  localparam logic [7:0] RCON [10] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                                       8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // byte i of a 128-bit block sits at bits 127-8i .. 120-8i
  function automatic logic [7:0] get_byte(input logic [127:0] v, input int unsigned i);
    get_byte = v[127-8*i -: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

>>> rtl/aescbc_round.sv
// one aes round plus its round key step
module aescbc_round (
  input  logic [127:0] state_in,
  input  logic [127:0] key_in,
  input  logic [7:0]   rcon,
  input  logic         do_mix,
  output logic [127:0] state_out,
  output logic [127:0] key_out
);

  logic [7:0] sb [16];
  logic [7:0] mx [16];
  logic [7:0] kb [16];
  logic [7:0] t  [4];
  logic [7:0] a0, a1, a2, a3, all;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      kb[i] = aescbc_pkg::get_byte(key_in, i);
    end
    t[0] = aescbc_pkg::SBOX[kb[13]] ^ rcon;
    t[1] = aescbc_pkg::SBOX[kb[14]];
    t[2] = aescbc_pkg::SBOX[kb[15]];
    t[3] = aescbc_pkg::SBOX[kb[12]];
    for (int i = 0; i < 4; i++) begin
      kb[i] = kb[i] ^ t[i];
    end
    for (int i = 4; i < 16; i++) begin
      kb[i] = kb[i] ^ kb[i-4];
    end
    // sub bytes and shift rows
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sb[c*4+r] = aescbc_pkg::SBOX[aescbc_pkg::get_byte(state_in, ((c + r) % 4) * 4 + r)];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = sb[c*4];
      a1 = sb[c*4+1];
      a2 = sb[c*4+2];
      a3 = sb[c*4+3];
      all = a0 ^ a1 ^ a2 ^ a3;
      mx[c*4]   = do_mix ? (a0 ^ all ^ aescbc_pkg::xtime(a0 ^ a1)) : a0;
      mx[c*4+1] = do_mix ? (a1 ^ all ^ aescbc_pkg::xtime(a1 ^ a2)) : a1;
      mx[c*4+2] = do_mix ? (a2 ^ all ^ aescbc_pkg::xtime(a2 ^ a3)) : a2;
      mx[c*4+3] = do_mix ? (a3 ^ all ^ aescbc_pkg::xtime(a3 ^ a0)) : a3;
    end
    for (int i = 0; i < 16; i++) begin
      state_out[127-8*i -: 8] = mx[i] ^ kb[i];
      key_out[127-8*i -: 8]   = kb[i];
    end
  end

endmodule

>>> rtl/aescbc_core.sv
// ten unrolled rounds from whitened input to ciphertext
module aescbc_core (
  input  logic [127:0] block_in,
  input  logic [127:0] key,
  output logic [127:0] block_out
);

  logic [127:0] st [11];
  logic [127:0] rk [11];

  assign st[0] = block_in ^ key;
  assign rk[0] = key;

  for (genvar g = 0; g < 10; g++) begin : g_round
    aescbc_round u_round (
      .state_in  (st[g]),
      .key_in    (rk[g]),
      .rcon      (aescbc_pkg::RCON[g]),
      .do_mix    (g != 9),
      .state_out (st[g+1]),
      .key_out   (rk[g+1])
    );
  end

  assign block_out = st[10];

endmodule

>>> rtl/aes128_cbc_encrypt.sv
// channel  | direction | handshake            | payload
// in_      | input     | in_valid / in_stall  | in_item   (plain_high, plain_low, restart)
// out_     | output    | out_valid / out_stall| out_item  (cipher_high, cipher_low)
// cfg_     | input     | cfg_we               | cfg_index, cfg_data
//
// one item per cycle while in_stall is low; the result appears in the cycle after the item is accepted
// all ten rounds sit between the chaining xor and the result register
// the chaining register loads the ciphertext with the result, so back-to-back items chain
// out_stall holds the result register; in_stall follows it only when a result waits
// reset clears key, iv, chaining value and out_valid
module aes128_cbc_encrypt (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  aescbc_pkg::in_item_t                in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output aescbc_pkg::out_item_t               out_item,
  input  logic                                cfg_we,
  input  logic [aescbc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [63:0]                         cfg_data
);

  logic [127:0] key_r, iv_r, chain_r;
  logic [127:0] out_r, out_nxt;
  logic         out_valid_r;
  logic         in_acc;
  logic [127:0] whiten;

  // accept whenever the result register is free or being drained
  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;

  // chaining value is the last ciphertext, or the iv on restart
  assign whiten = {in_item.plain_high, in_item.plain_low}
                ^ (in_item.restart ? iv_r : chain_r);

  aescbc_core u_core (
    .block_in  (whiten),
    .key       (key_r),
    .block_out (out_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r       <= '0;
      iv_r        <= '0;
      chain_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          aescbc_pkg::REG_KEY_HIGH: key_r[127:64] <= cfg_data;
          aescbc_pkg::REG_KEY_LOW:  key_r[63:0]   <= cfg_data;
          aescbc_pkg::REG_IV_HIGH:  iv_r[127:64]  <= cfg_data;
          aescbc_pkg::REG_IV_LOW:   iv_r[63:0]    <= cfg_data;
          default: ;
        endcase
      end
      if (in_acc) begin
        chain_r     <= out_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload register, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_item.cipher_high = out_r[127:64];
  assign out_item.cipher_low  = out_r[63:0];

endmodule

>>> rtl/aescbc_check.sv
module aescbc_check (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input aescbc_pkg::out_item_t out_item
);

  // every accepted item shows a result next cycle
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid) else $error("missing result");

  // input is held off only while a result waits
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall) else $error("spurious in_stall");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item)) else $error("result changed");

  // a result taken with no new item disappears
  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !in_valid |=> !out_valid) else $error("stale result");

endmodule

bind aes128_cbc_encrypt aescbc_check u_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

>>> test/aes128_cbc_encrypt_test.sv
`timescale 1ns / 100ps

module aes128_cbc_encrypt_test;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  aescbc_pkg::in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  aescbc_pkg::out_item_t   out_item;
  logic        cfg_we = 1'b0;
  logic [aescbc_pkg::CFG_IDX_W-1:0] cfg_index = aescbc_pkg::REG_KEY_HIGH;
  logic [63:0] cfg_data = '0;

  // predictor copy of configuration and chaining state
  logic [63:0] key_q [2];
  logic [63:0] iv_q [2];
  logic [127:0] chain_q;

  // expected ciphertexts, oldest first
  aescbc_pkg::out_item_t cipher_queue [$];
  int unsigned fail_count = 0;
  bit hold_off = 1'b0;

  aes128_cbc_encrypt u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // gf doubling written out locally; sbox and rcon tables taken from the package
  function automatic logic [7:0] gf_double(input logic [7:0] x);
    gf_double = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // plain aes-128 encryption of one block, byte 0 in the top bits
  function automatic logic [127:0] aes_encrypt(input logic [127:0] blk,
                                               input logic [127:0] key);
    logic [7:0] st [16];
    logic [7:0] rk [16];
    logic [7:0] tmp [16];
    logic [7:0] t [4];
    logic [7:0] a0, a1, a2, a3, all;
    logic [127:0] res;
    for (int i = 0; i < 16; i++) begin
      st[i] = blk[127-8*i -: 8] ^ key[127-8*i -: 8];
      rk[i] = key[127-8*i -: 8];
    end
    for (int rnd = 0; rnd < 10; rnd++) begin
      // round key schedule step
      t[0] = aescbc_pkg::SBOX[rk[13]] ^ aescbc_pkg::RCON[rnd];
      t[1] = aescbc_pkg::SBOX[rk[14]];
      t[2] = aescbc_pkg::SBOX[rk[15]];
      t[3] = aescbc_pkg::SBOX[rk[12]];
      for (int i = 0; i < 4; i++) rk[i] = rk[i] ^ t[i];
      for (int i = 4; i < 16; i++) rk[i] = rk[i] ^ rk[i-4];
      // sub bytes and shift rows
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          tmp[c*4+r] = aescbc_pkg::SBOX[st[((c+r)%4)*4+r]];
      st = tmp;
      // mix columns, skipped in the last round
      if (rnd < 9) begin
        for (int c = 0; c < 4; c++) begin
          a0 = st[c*4]; a1 = st[c*4+1]; a2 = st[c*4+2]; a3 = st[c*4+3];
          all = a0 ^ a1 ^ a2 ^ a3;
          st[c*4]   = a0 ^ all ^ gf_double(a0 ^ a1);
          st[c*4+1] = a1 ^ all ^ gf_double(a1 ^ a2);
          st[c*4+2] = a2 ^ all ^ gf_double(a2 ^ a3);
          st[c*4+3] = a3 ^ all ^ gf_double(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) st[i] = st[i] ^ rk[i];
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i];
    return res;
  endfunction

  // cbc step of the predictor: pick chaining value, encrypt, keep result
  function automatic aescbc_pkg::out_item_t predict_cipher(input aescbc_pkg::in_item_t it);
    logic [127:0] chain_in;
    logic [127:0] ct;
    aescbc_pkg::out_item_t o;
    chain_in = it.restart ? {iv_q[0], iv_q[1]} : chain_q;
    ct = aes_encrypt({it.plain_high, it.plain_low} ^ chain_in, {key_q[0], key_q[1]});
    chain_q = ct;
    o.cipher_high = ct[127:64];
    o.cipher_low = ct[63:0];
    return o;
  endfunction

  // register write, only done while the block is idle; we drops after the last one
  task automatic write_reg(input logic [aescbc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [63:0] val, input bit last);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (last) cfg_we <= 1'b0;
    case (idx)
      aescbc_pkg::REG_KEY_HIGH: key_q[0] = val;
      aescbc_pkg::REG_KEY_LOW:  key_q[1] = val;
      aescbc_pkg::REG_IV_HIGH:  iv_q[0] = val;
      aescbc_pkg::REG_IV_LOW:   iv_q[1] = val;
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [127:0] key, input logic [127:0] iv);
    write_reg(aescbc_pkg::REG_KEY_HIGH, key[127:64], 1'b0);
    write_reg(aescbc_pkg::REG_KEY_LOW, key[63:0], 1'b0);
    write_reg(aescbc_pkg::REG_IV_HIGH, iv[127:64], 1'b0);
    write_reg(aescbc_pkg::REG_IV_LOW, iv[63:0], 1'b1);
  endtask

  // send one item, after a random gap when gaps is set; expectation made at acceptance
  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo,
                            input logic rs, input bit gaps);
    int unsigned gap;
    aescbc_pkg::in_item_t it;
    gap = gaps ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.plain_high = hi;
    it.plain_low = lo;
    it.restart = rs;
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    cipher_queue.push_back(predict_cipher(it));
  endtask

  // wait until every expected result has arrived, plus a short drain
  task automatic drain;
    int unsigned guard;
    guard = 0;
    in_valid <= 1'b0;
    while (cipher_queue.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64;
    return {$urandom, $urandom};
  endfunction

  // fips-197 known vector plus zero key, zero chain after reset
  task automatic test_directed;
    send_block(64'h0, 64'h0, 1'b0, 1'b0);       // chaining from reset value
    send_block(64'h0, 64'h0, 1'b1, 1'b0);       // iv still reset zero
    drain();
    write_all(128'h000102030405060708090a0b0c0d0e0f, 128'h0);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1, 1'b0);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0, 1'b0);
    drain();
    write_all({128{1'b1}}, {128{1'b1}});
    send_block('1, '1, 1'b1, 1'b0);
    send_block('0, '0, 1'b0, 1'b1);
    send_block('1, '0, 1'b0, 1'b0);
    send_block('0, '1, 1'b1, 1'b1);
    drain();
    // new iv only seen by a restart block
    write_reg(aescbc_pkg::REG_IV_HIGH, 64'h0123456789abcdef, 1'b1);
    send_block(64'h5555aaaa5555aaaa, 64'haaaa5555aaaa5555, 1'b0, 1'b0);
    send_block(64'h5555aaaa5555aaaa, 64'haaaa5555aaaa5555, 1'b1, 1'b0);
    drain();
  endtask

  // random sequences of chained blocks, restart on about one item in ten at random
  task automatic test_random_chains;
    for (int ph = 0; ph < 8; ph++) begin
      write_all({rand64(), rand64()}, {rand64(), rand64()});
      for (int n = 0; n < 130; n++)
        send_block(rand64(), rand64(), ($urandom_range(0, 9) == 0), ($urandom_range(0, 3) != 0));
      drain();
    end
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic test_backpressure;
    write_all({rand64(), rand64()}, {rand64(), rand64()});
    hold_off = 1'b1;
    for (int n = 0; n < 60; n++)
      send_block(rand64(), rand64(), n == 0, 1'b0);
    drain();
    write_all(128'h0, 128'h0);
    for (int n = 0; n < 40; n++)
      send_block(rand64(), rand64(), 1'($urandom_range(0, 1)), 1'b0);
    drain();
  endtask

  // receiver: random stall per item, a long hold-off when asked
  initial begin
    int unsigned wait_cycles;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        hold_off = 1'b0;
        out_stall <= 1'b1;
        repeat (200) @(posedge clk);
        out_stall <= 1'b0;
      end else if (out_valid && !out_stall) begin
        wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        if (wait_cycles != 0) begin
          out_stall <= 1'b1;
          repeat (wait_cycles) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // result checker, sampled at the edge
  always @(posedge clk) begin
    aescbc_pkg::out_item_t exp_item;
    if (rst_n && out_valid && !out_stall) begin
      if (cipher_queue.size() == 0) begin
        $display("%0t: unexpected item %h", $time, out_item);
        fail_count++;
      end else begin
        exp_item = cipher_queue.pop_front();
        if (out_item.cipher_high !== exp_item.cipher_high) begin
          $display("%0t: cipher_high expected %h actual %h", $time,
                   exp_item.cipher_high, out_item.cipher_high);
          fail_count++;
        end
        if (out_item.cipher_low !== exp_item.cipher_low) begin
          $display("%0t: cipher_low expected %h actual %h", $time,
                   exp_item.cipher_low, out_item.cipher_low);
          fail_count++;
        end
      end
    end
  end

  initial begin
    key_q = '{64'h0, 64'h0};
    iv_q = '{64'h0, 64'h0};
    chain_q = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_chains();
    test_backpressure();
    drain();
    if (cipher_queue.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("aes128_cbc_encrypt test passed");
    end else begin
      $display("aes128_cbc_encrypt test failed");
    end
    $finish;
  end

  // timeout watchdog
  initial begin
    #2000000;
    $display("aes128_cbc_encrypt test failed");
    $finish;
  end

endmodule

>>> sim.f
rtl/aescbc_pkg.sv
rtl/aescbc_round.sv
rtl/aescbc_core.sv
rtl/aes128_cbc_encrypt.sv
rtl/aescbc_check.sv
test/aes128_cbc_encrypt_test.sv
